[rtl/bres_pkg.sv]
// ----------------------------------------------------------------------------
// bres_pkg
// Shared widths, register map and status types for the line pixel writer.
// ----------------------------------------------------------------------------
package bres_pkg;

  localparam int ADDR_W     = 32;
  localparam int COLOUR_W   = 16;
  localparam int PITCH_W    = 12;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_BASE = 1'b0;
  localparam logic REG_PITCH      = 1'b1;

  localparam logic [ADDR_W-1:0]  FRAME_BASE_RESET = 32'h0600_0000;
  localparam logic [PITCH_W-1:0] PITCH_RESET      = 12'd480;

  // walker status seen by the top level
  typedef struct packed {
    logic drawing;  // a line is in progress
    logic emit;     // a pixel word is loaded into the output register
    logic last;     // the emitted pixel ends its line
  } back_status_t;

endpackage

[rtl/bresenham_line_pixel_writer_core.sv]
// ----------------------------------------------------------------------------
// bresenham_line_pixel_writer_core
// Bresenham line rasterizer producing one framebuffer pixel word per step.
// ----------------------------------------------------------------------------
// A start word (mode 0) loads both endpoints and a colour and produces no
// output; each step word (mode 1) produces one pixel write, walking from the
// first endpoint to the second inclusive, with final_pixel set on the last.
// A step word while no line is in progress is dropped; a start word replaces
// any line in progress. The block takes one word per clock while its queue
// has room and emits one pixel word per clock while the output is not
// stalled: the walker updates its position, error term and address together,
// so a step can follow a step directly. An accepted step word is held in the
// queue, then the walker loads its pixel word into the output register. The
// start address base + y * pitch + 2x is formed in the front with one
// multiplier. Registers sit on an APB-style port: frame_base at byte address
// 0, pitch_bytes at 4; write them only while no line words are in flight.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_writer_core #(
  parameter int COORD_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bres_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [bres_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [bres_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic [COORD_BITS-1:0]               start_x,
  input  logic [COORD_BITS-1:0]               start_y,
  input  logic [COORD_BITS-1:0]               end_x,
  input  logic [COORD_BITS-1:0]               end_y,
  input  logic [bres_pkg::COLOUR_W-1:0]       colour,
  // pixel words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bres_pkg::ADDR_W-1:0]         pixel_address,
  output logic [COORD_BITS-1:0]               pixel_x,
  output logic [COORD_BITS-1:0]               pixel_y,
  output logic [bres_pkg::COLOUR_W-1:0]       pixel_value,
  output logic                                final_pixel
);

  localparam int CMD_W = 6 * COORD_BITS + 56;

  logic [bres_pkg::ADDR_W-1:0]  frame_base;
  logic [bres_pkg::PITCH_W-1:0] pitch_bytes;
  logic                         cfg_write;

  logic [CMD_W-1:0]             front_cmd;
  logic [CMD_W-1:0]             head;
  logic                         head_valid;
  logic                         push;
  logic                         pop;
  logic                         q_full;
  bres_pkg::back_status_t       status;

  // --------------------------------------------------------------------------
  // Configuration registers; the write lands in the access phase.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base  <= bres_pkg::FRAME_BASE_RESET;
      pitch_bytes <= bres_pkg::PITCH_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        bres_pkg::REG_FRAME_BASE: frame_base  <= pwdata;
        bres_pkg::REG_PITCH:      pitch_bytes <= pwdata[bres_pkg::PITCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bres_pkg::REG_FRAME_BASE: prdata = frame_base;
      bres_pkg::REG_PITCH:      prdata = bres_pkg::CFG_DATA_W'(pitch_bytes);
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front: accept a word whenever the queue has room, and build its command.
  // --------------------------------------------------------------------------
  assign in_stall = q_full;
  assign push     = in_valid & ~in_stall;

  bres_front #(
    .CW (COORD_BITS)
  ) u_front (
    .mode        (mode),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .colour      (colour),
    .frame_base  (frame_base),
    .pitch_bytes (pitch_bytes),
    .cmd         (front_cmd)
  );

  // Queue: lets the front keep taking words while the output side stalls.
  bres_queue #(
    .W (CMD_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (front_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (q_full)
  );

  // Back: walk the line, one pixel per step command while a line is in progress.
  bres_back #(
    .CW (COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .pitch_bytes   (pitch_bytes),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .pixel_address (pixel_address),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_value   (pixel_value),
    .final_pixel   (final_pixel),
    .status        (status)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // never overwrite a pixel word that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    status.emit |-> !(out_valid && out_stall))
    else $error("pixel word overwritten while stalled");

  // the last pixel of a line ends drawing
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (status.emit && status.last) |=> !status.drawing)
    else $error("walker still drawing after the last pixel");

  // a pixel word appears only after the walker emitted one
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(status.emit))
    else $error("pixel word without a walker step");
`endif

endmodule

[rtl/bres_front.sv]
// ----------------------------------------------------------------------------
// bres_front
// Classifies an input item and builds its command: line setup for a start,
// a bare step request otherwise.
// ----------------------------------------------------------------------------
module bres_front #(
  parameter int CW = 10
) (
  input  logic                               mode,
  input  logic [CW-1:0]                      start_x,
  input  logic [CW-1:0]                      start_y,
  input  logic [CW-1:0]                      end_x,
  input  logic [CW-1:0]                      end_y,
  input  logic [bres_pkg::COLOUR_W-1:0]      colour,
  input  logic [bres_pkg::ADDR_W-1:0]        frame_base,
  input  logic [bres_pkg::PITCH_W-1:0]       pitch_bytes,
  output logic [6*CW+55:0]                   cmd
);

  typedef struct packed {
    logic                             is_start;
    logic                             x_down;
    logic                             y_down;
    logic                             x_major;
    logic [CW-1:0]                    col;
    logic [CW-1:0]                    row;
    logic [CW-1:0]                    span_x;
    logic [CW-1:0]                    span_y;
    logic signed [CW+2:0]             err;
    logic [CW:0]                      left;
    logic [bres_pkg::ADDR_W-1:0]      addr;
    logic [bres_pkg::COLOUR_W-1:0]    colour;
  } cmd_t;

  cmd_t                            c;
  logic [CW-1:0]                   major;
  logic [CW-1:0]                   minor;
  logic [CW+bres_pkg::PITCH_W-1:0] row_off;

  always_comb begin
    c.is_start = ~mode;
    c.x_down   = start_x > end_x;
    c.y_down   = start_y > end_y;
    c.span_x   = c.x_down ? start_x - end_x : end_x - start_x;
    c.span_y   = c.y_down ? start_y - end_y : end_y - start_y;
    c.x_major  = c.span_x >= c.span_y;
    major      = c.x_major ? c.span_x : c.span_y;
    minor      = c.x_major ? c.span_y : c.span_x;
    c.err      = signed'({2'b00, minor, 1'b0}) - signed'({3'b000, major});
    c.left     = {1'b0, major} + (CW+1)'(1);
    c.col      = start_x;
    c.row      = start_y;
    row_off    = start_y * pitch_bytes;
    c.addr     = frame_base + bres_pkg::ADDR_W'(row_off)
               + bres_pkg::ADDR_W'({start_x, 1'b0});
    c.colour   = colour;
  end

  assign cmd = c;

endmodule

[rtl/bres_queue.sv]
// ----------------------------------------------------------------------------
// bres_queue
// Two-entry command queue between the front and the walker.
// ----------------------------------------------------------------------------
module bres_queue #(
  parameter int W = 116
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head,
  output logic         full
);

  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign head       = slots[rd_ptr];
  assign head_valid = count != 2'd0;
  assign full       = count == 2'd2;

endmodule

[rtl/bres_back.sv]
// ----------------------------------------------------------------------------
// bres_back
// Line walker: executes queued commands and emits one pixel word per step.
// ----------------------------------------------------------------------------
module bres_back #(
  parameter int CW = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  logic [6*CW+55:0]                head,
  output logic                            pop,
  input  logic [bres_pkg::PITCH_W-1:0]    pitch_bytes,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [bres_pkg::ADDR_W-1:0]     pixel_address,
  output logic [CW-1:0]                   pixel_x,
  output logic [CW-1:0]                   pixel_y,
  output logic [bres_pkg::COLOUR_W-1:0]   pixel_value,
  output logic                            final_pixel,
  output bres_pkg::back_status_t          status
);

  typedef struct packed {
    logic                             is_start;
    logic                             x_down;
    logic                             y_down;
    logic                             x_major;
    logic [CW-1:0]                    col;
    logic [CW-1:0]                    row;
    logic [CW-1:0]                    span_x;
    logic [CW-1:0]                    span_y;
    logic signed [CW+2:0]             err;
    logic [CW:0]                      left;
    logic [bres_pkg::ADDR_W-1:0]      addr;
    logic [bres_pkg::COLOUR_W-1:0]    colour;
  } cmd_t;

  cmd_t                           h;
  cmd_t                           cur;
  cmd_t                           cur_next;
  logic                           drawing;
  logic                           out_free;
  logic                           emit;
  logic                           last;
  logic                           step_minor;
  logic                           step_x;
  logic                           step_y;
  logic [CW-1:0]                  major;
  logic [CW-1:0]                  minor;
  logic [bres_pkg::ADDR_W-1:0]    dx_addr;
  logic [bres_pkg::ADDR_W-1:0]    dy_addr;
  logic [bres_pkg::ADDR_W-1:0]    pitch_ext;

  assign h        = head;
  assign out_free = ~out_valid | ~out_stall;
  assign pop      = head_valid & (h.is_start | out_free);
  assign emit     = pop & ~h.is_start & drawing;
  assign last     = cur.left[CW:1] == '0;

  // next walker position
  always_comb begin
    cur_next   = cur;
    major      = cur.x_major ? cur.span_x : cur.span_y;
    minor      = cur.x_major ? cur.span_y : cur.span_x;
    step_minor = ~cur.err[CW+2];
    step_x     = cur.x_major | step_minor;
    step_y     = ~cur.x_major | step_minor;
    pitch_ext  = bres_pkg::ADDR_W'(pitch_bytes);

    dx_addr = '0;
    if (step_x) begin
      dx_addr = cur.x_down ? -bres_pkg::ADDR_W'(2) : bres_pkg::ADDR_W'(2);
      cur_next.col = cur.x_down ? cur.col - CW'(1) : cur.col + CW'(1);
    end
    dy_addr = '0;
    if (step_y) begin
      dy_addr = cur.y_down ? -pitch_ext : pitch_ext;
      cur_next.row = cur.y_down ? cur.row - CW'(1) : cur.row + CW'(1);
    end

    cur_next.addr = cur.addr + dx_addr + dy_addr;
    cur_next.err  = cur.err + signed'({2'b00, minor, 1'b0})
                  - (step_minor ? signed'({2'b00, major, 1'b0}) : '0);
    cur_next.left = cur.left - (CW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drawing <= 1'b0;
    end else if (pop && h.is_start) begin
      drawing <= 1'b1;
    end else if (emit && last) begin
      drawing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && h.is_start) begin
      cur <= h;
    end else if (emit) begin
      if (last) begin
        cur.left <= '0;
      end else begin
        cur <= cur_next;
      end
    end
  end

  // output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_address <= cur.addr;
      pixel_x       <= cur.col;
      pixel_y       <= cur.row;
      pixel_value   <= cur.colour;
      final_pixel   <= cur.left == (CW+1)'(1);
    end
  end

  assign status.drawing = drawing;
  assign status.emit    = emit;
  assign status.last    = last;

endmodule

[tb/tb_bresenham_line_pixel_writer_core.sv]
// ----------------------------------------------------------------------------
// tb_bresenham_line_pixel_writer_core
// Self-checking testbench for the Bresenham line pixel writer.
// ----------------------------------------------------------------------------
// Line words go in on the valid/stall input channel. An internal line walker
// tracks position, error term and address, and queues one expected pixel word
// for each step word that hits a line in progress. A checker pops that queue
// on every pixel word accepted at the output. The tests are run in turn:
// - directed shapes;
// - a sweep of register settings, extremes included;
// - a long receiver hold-off that fills the block;
// - random line traffic, ending with a stretch with no idling.
// Both sides idle in short random bursts. A watchdog ends the run when no
// word moves for too long.
// ----------------------------------------------------------------------------
module tb_bresenham_line_pixel_writer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW              = 10;
  localparam int COORD_MAX       = (1 << CW) - 1;
  localparam int SETTLE_CYCLES   = 8;     // pipeline is two deep; leave margin
  localparam int WATCHDOG_CYCLES = 2000;  // far above the longest hold-off
  localparam int REPORT_LIMIT    = 10;

  // input word modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  typedef struct packed {
    logic                          mode;
    logic [CW-1:0]                 sx;
    logic [CW-1:0]                 sy;
    logic [CW-1:0]                 ex;
    logic [CW-1:0]                 ey;
    logic [bres_pkg::COLOUR_W-1:0] color;
  } line_word_t;

  typedef struct packed {
    logic [bres_pkg::ADDR_W-1:0]   addr;
    logic [CW-1:0]                 x;
    logic [CW-1:0]                 y;
    logic [bres_pkg::COLOUR_W-1:0] value;
    logic                          last;
  } pixel_word_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            psel     = 1'b0;
  logic                            penable  = 1'b0;
  logic                            pwrite   = 1'b0;
  logic [bres_pkg::CFG_ADDR_W-1:0] paddr    = '0;
  logic [bres_pkg::CFG_DATA_W-1:0] pwdata   = '0;
  logic [bres_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            mode     = MODE_START;
  logic [CW-1:0]                   start_x  = '0;
  logic [CW-1:0]                   start_y  = '0;
  logic [CW-1:0]                   end_x    = '0;
  logic [CW-1:0]                   end_y    = '0;
  logic [bres_pkg::COLOUR_W-1:0]   colour   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [bres_pkg::ADDR_W-1:0]     pixel_address;
  logic [CW-1:0]                   pixel_x;
  logic [CW-1:0]                   pixel_y;
  logic [bres_pkg::COLOUR_W-1:0]   pixel_value;
  logic                            final_pixel;

  bresenham_line_pixel_writer_core #(.COORD_BITS(CW)) DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .colour       (colour),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_address(pixel_address),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_value  (pixel_value),
    .final_pixel  (final_pixel)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Line walker: own copy of registers and line state
  // --------------------------------------------------------------------------
  logic [bres_pkg::ADDR_W-1:0]   canvas_base  = bres_pkg::FRAME_BASE_RESET;
  logic [bres_pkg::PITCH_W-1:0]  row_pitch    = bres_pkg::PITCH_RESET;
  logic                          walking      = 1'b0;
  logic [CW-1:0]                 at_x         = '0;
  logic [CW-1:0]                 at_y         = '0;
  logic [bres_pkg::ADDR_W-1:0]   at_addr      = '0;
  int                            bres_err     = 0;
  int                            pixels_to_go = 0;
  logic [CW-1:0]                 run_x        = '0;
  logic [CW-1:0]                 run_y        = '0;
  logic                          x_back       = 1'b0;
  logic                          y_back       = 1'b0;
  logic                          x_long       = 1'b0;
  logic [bres_pkg::COLOUR_W-1:0] line_color   = '0;

  pixel_word_t expected_pixels[$];
  int          useful_words = 0;   // starts plus steps that hit a live line
  int          mismatches   = 0;

  function automatic void step_x();
    if (x_back) begin
      at_x    = at_x - 1'b1;
      at_addr = at_addr - 32'd2;
    end else begin
      at_x    = at_x + 1'b1;
      at_addr = at_addr + 32'd2;
    end
  endfunction

  function automatic void step_y();
    if (y_back) begin
      at_y    = at_y - 1'b1;
      at_addr = at_addr - 32'(row_pitch);
    end else begin
      at_y    = at_y + 1'b1;
      at_addr = at_addr + 32'(row_pitch);
    end
  endfunction

  // Apply one accepted word to the walker; queue the pixel it produces.
  function automatic void advance_line_walker(input line_word_t w);
    pixel_word_t p;
    if (w.mode == MODE_START) begin
      x_back = w.sx > w.ex;
      run_x  = x_back ? w.sx - w.ex : w.ex - w.sx;
      y_back = w.sy > w.ey;
      run_y  = y_back ? w.sy - w.ey : w.ey - w.sy;
      x_long = run_x >= run_y;
      if (x_long) begin
        bres_err     = 2 * int'(run_y) - int'(run_x);
        pixels_to_go = int'(run_x) + 1;
      end else begin
        bres_err     = 2 * int'(run_x) - int'(run_y);
        pixels_to_go = int'(run_y) + 1;
      end
      at_x       = w.sx;
      at_y       = w.sy;
      at_addr    = canvas_base + 32'(w.sy) * 32'(row_pitch) + 32'(w.sx) * 32'd2;
      line_color = w.color;
      walking    = 1'b1;
      useful_words++;
    end else if (walking) begin
      useful_words++;
      p.addr  = at_addr;
      p.x     = at_x;
      p.y     = at_y;
      p.value = line_color;
      p.last  = (pixels_to_go == 1);
      expected_pixels.push_back(p);
      if (pixels_to_go <= 1) begin
        pixels_to_go = 0;
        walking      = 1'b0;
      end else begin
        pixels_to_go--;
        // minor axis moves first when the error term is non-negative
        if (x_long) begin
          if (bres_err >= 0) begin
            bres_err -= 2 * int'(run_x);
            step_y();
          end
          bres_err += 2 * int'(run_y);
          step_x();
        end else begin
          if (bres_err >= 0) begin
            bres_err -= 2 * int'(run_y);
            step_x();
          end
          bres_err += 2 * int'(run_x);
          step_y();
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Pixel checker: compare each accepted pixel word with the oldest one due
  // --------------------------------------------------------------------------
  pixel_word_t seen_pixel;
  pixel_word_t due_pixel;

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      seen_pixel = {pixel_address, pixel_x, pixel_y, pixel_value, final_pixel};
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected pixel word addr=%h x=%0d y=%0d value=%h last=%b",
                   $realtime, seen_pixel.addr, seen_pixel.x, seen_pixel.y,
                   seen_pixel.value, seen_pixel.last);
      end else begin
        due_pixel = expected_pixels.pop_front();
        if (seen_pixel !== due_pixel) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: pixel mismatch exp addr=%h x=%0d y=%0d value=%h last=%b",
                     $realtime, due_pixel.addr, due_pixel.x, due_pixel.y,
                     due_pixel.value, due_pixel.last,
                     " | got addr=%h x=%0d y=%0d value=%h last=%b",
                     seen_pixel.addr, seen_pixel.x, seen_pixel.y,
                     seen_pixel.value, seen_pixel.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles in which no word moves on either channel
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no word moved for %0d cycles", $realtime, WATCHDOG_CYCLES);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off on request
  // --------------------------------------------------------------------------
  logic sink_jitter     = 1'b1;
  int   sink_hold_left  = 0;
  int   sink_burst_left = 0;

  always @(negedge clk) begin
    if (sink_hold_left > 0) begin
      out_stall <= 1'b1;
      sink_hold_left--;
    end else if (sink_burst_left > 0) begin
      out_stall <= 1'b1;
      sink_burst_left--;
    end else if (sink_jitter && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      sink_burst_left = $urandom_range(0, 2);   // random burst length
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  logic src_jitter = 1'b1;

  // Offer one word; call and return at a falling edge. Valid stays high on
  // return so back-to-back words follow without a gap.
  task automatic push_word(input line_word_t w);
    if (src_jitter && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= w.mode;
    start_x  <= w.sx;
    start_y  <= w.sy;
    end_x    <= w.ex;
    end_y    <= w.ey;
    colour   <= w.color;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_line_walker(w);
    @(negedge clk);
  endtask

  // Drop valid, wait for every pixel due, then let the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // edge where the access phase meets pready.
  task automatic write_reg(input logic idx,
                           input logic [bres_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bres_pkg::CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == bres_pkg::REG_FRAME_BASE)
      canvas_base = value;
    else
      row_pitch = value[bres_pkg::PITCH_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic line_word_t random_step_word();
    line_word_t w;
    // ignored fields still toggle
    w.mode  = MODE_STEP;
    w.sx    = CW'($urandom);
    w.sy    = CW'($urandom);
    w.ex    = CW'($urandom);
    w.ey    = CW'($urandom);
    w.color = bres_pkg::COLOUR_W'($urandom);
    return w;
  endfunction

  // Mostly short lines anywhere on the canvas, now and then a long one.
  function automatic line_word_t random_line_start();
    line_word_t w;
    int reach;
    int ex;
    int ey;
    w.mode  = MODE_START;
    w.sx    = CW'($urandom);
    w.sy    = CW'($urandom);
    w.color = bres_pkg::COLOUR_W'($urandom);
    reach   = ($urandom_range(0, 15) == 0) ? COORD_MAX : $urandom_range(0, 12);
    ex = int'(w.sx) + int'($urandom_range(0, 2 * reach)) - reach;
    ey = int'(w.sy) + int'($urandom_range(0, 2 * reach)) - reach;
    w.ex = CW'((ex < 0) ? 0 : (ex > COORD_MAX) ? COORD_MAX : ex);
    w.ey = CW'((ey < 0) ? 0 : (ey > COORD_MAX) ? COORD_MAX : ey);
    return w;
  endfunction

  task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                           input logic [bres_pkg::COLOUR_W-1:0] color,
                           input int steps);
    line_word_t w;
    w.mode  = MODE_START;
    w.sx    = CW'(sx);
    w.sy    = CW'(sy);
    w.ex    = CW'(ex);
    w.ey    = CW'(ey);
    w.color = color;
    push_word(w);
    repeat (steps) push_word(random_step_word());
  endtask

  // Random traffic until the given number of useful words went in. Most
  // lines are walked to the end; some are cut short by the next start, some
  // get extra steps that land on an idle block.
  task automatic run_lines(input int target);
    line_word_t w;
    int goal;
    int dx;
    int dy;
    int n;
    int steps;
    goal = useful_words + target;
    while (useful_words < goal) begin
      if ($urandom_range(0, 9) == 0) push_word(random_step_word());
      w  = random_line_start();
      dx = int'(w.ex) - int'(w.sx);
      dy = int'(w.ey) - int'(w.sy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      n = ((dx >= dy) ? dx : dy) + 1;
      case ($urandom_range(0, 9))
        0:       steps = $urandom_range(0, n - 1);
        1:       steps = n + $urandom_range(1, 3);
        default: steps = n;
      endcase
      if (steps > 40) steps = $urandom_range(1, 40);
      push_word(w);
      repeat (steps) push_word(random_step_word());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_shapes();
    push_word(random_step_word());              // step with no line: drop
    draw_line(0, 0, 0, 0, 16'h0000, 2);         // single point, then idle step
    draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF, 1);
    draw_line(COORD_MAX, 0, COORD_MAX - 3, 0, 16'hA5A5, 4);   // horizontal, leftward
    draw_line(0, COORD_MAX, 0, COORD_MAX - 2, 16'h5A5A, 3);   // vertical, upward
    draw_line(5, 5, 6, 8, 16'h1234, 4);                       // steep
    draw_line(100, 100, 110, 103, 16'hBEEF, 2);               // cut short by next start
    draw_line(3, 900, 0, 901, 16'h8001, 4);
    settle();
  endtask

  task automatic test_register_settings();
    write_reg(bres_pkg::REG_FRAME_BASE, 32'hFFFF_FFF0);
    write_reg(bres_pkg::REG_PITCH, 32'd2048);
    run_lines(40);
    settle();
    write_reg(bres_pkg::REG_FRAME_BASE, 32'h0000_0000);
    write_reg(bres_pkg::REG_PITCH, 32'd2);
    run_lines(40);
    settle();
    // odd base and odd pitch are used as given
    write_reg(bres_pkg::REG_FRAME_BASE, 32'h1234_5677);
    write_reg(bres_pkg::REG_PITCH, 32'd1);
    run_lines(40);
    settle();
    // zero pitch folds every row onto the same addresses
    write_reg(bres_pkg::REG_FRAME_BASE, 32'hFFFF_FFFF);
    write_reg(bres_pkg::REG_PITCH, 32'd0);
    run_lines(40);
    settle();
    write_reg(bres_pkg::REG_FRAME_BASE, $urandom);
    write_reg(bres_pkg::REG_PITCH, 32'hFFFF_FFFF);        // keeps the low 12 bits
    run_lines(40);
    settle();
  endtask

  // Hold the receiver off while steps keep coming so the block fills and
  // stalls its input.
  task automatic test_backpressure();
    write_reg(bres_pkg::REG_FRAME_BASE, bres_pkg::FRAME_BASE_RESET);
    write_reg(bres_pkg::REG_PITCH, 32'(bres_pkg::PITCH_RESET));
    src_jitter     = 1'b0;
    sink_hold_left = 100;
    draw_line(1000, 900, 840, 1023, 16'hC3C3, 161);
    src_jitter     = 1'b1;
    settle();
  endtask

  task automatic test_random_lines();
    write_reg(bres_pkg::REG_FRAME_BASE, $urandom & 32'hFFFF_FFFE);
    write_reg(bres_pkg::REG_PITCH,
              ($urandom & 32'hFFFF_F000) | (32'($urandom_range(1, 1024)) * 2));
    run_lines(200);
    // last part at full rate on both sides
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    run_lines(80);
    settle();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_directed_shapes();
    test_register_settings();
    test_backpressure();
    test_random_lines();
    if (mismatches == 0 && expected_pixels.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
